/* rtl/core/fp_instruction_decoder_assert.svh */
// Assertion macros shared by the floating-point instruction decoder checks.
// Needs nothing else; take it in by include from the files that assert.
`ifndef FP_INSTRUCTION_DECODER_ASSERT_SVH
`define FP_INSTRUCTION_DECODER_ASSERT_SVH

`define FPID_ASSERT_ALWAYS(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("fpid check failed: condition");

`define FPID_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpid check failed: implication");

`define FPID_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpid check failed: next cycle");

`endif

/* rtl/core/fpid_pkg.sv */
// Types, codes and constants of the floating-point instruction decoder.
// Used by the decoder modules, the checkers and the testbench.
package fpid_pkg;

    localparam logic [6:0] OPC_FLW    = 7'h07;
    localparam logic [6:0] OPC_FSW    = 7'h27;
    localparam logic [6:0] OPC_FMADD  = 7'h43;
    localparam logic [6:0] OPC_FMSUB  = 7'h47;
    localparam logic [6:0] OPC_FNMSUB = 7'h4B;
    localparam logic [6:0] OPC_FNMADD = 7'h4F;
    localparam logic [6:0] OPC_OPFP   = 7'h53;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [4:0] F5_ADD    = 5'h00;
    localparam logic [4:0] F5_SUB    = 5'h01;
    localparam logic [4:0] F5_MUL    = 5'h02;
    localparam logic [4:0] F5_DIV    = 5'h03;
    localparam logic [4:0] F5_SGNJ   = 5'h04;
    localparam logic [4:0] F5_MINMAX = 5'h05;
    localparam logic [4:0] F5_SQRT   = 5'h0B;
    localparam logic [4:0] F5_CMP    = 5'h14;
    localparam logic [4:0] F5_CVTWS  = 5'h18;
    localparam logic [4:0] F5_CVTSW  = 5'h1A;
    localparam logic [4:0] F5_MVXW   = 5'h1C;
    localparam logic [4:0] F5_MVWX   = 5'h1E;

    localparam logic [11:0] CSR_LOW   = 12'h001;
    localparam logic [11:0] CSR_HIGH  = 12'h003;
    localparam logic [2:0]  F3_CSRRW  = 3'b001;
    localparam logic [2:0]  F3_MV_MAX = 3'b001;

    localparam int unsigned CYC_W     = 8;
    localparam int unsigned NUM_CYC   = 7;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CYC_DEFAULT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYC_ADD_SUB = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CYC_MUL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CYC_DIV     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CYC_SQRT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CYC_CMP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CYC_CVT     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ZFINX       = 3'd7;

    localparam logic [CYC_W-1:0] CYC_RESET = 8'd1;

    localparam logic [3:0] ROUTE_FROM_MEM = 4'b0001;
    localparam logic [3:0] ROUTE_TO_MEM   = 4'b0010;
    localparam logic [3:0] ROUTE_TO_INT   = 4'b0100;
    localparam logic [3:0] ROUTE_FROM_INT = 4'b1000;

    localparam logic [2:0] USE_NONE = 3'b000;
    localparam logic [2:0] USE_RS1  = 3'b001;
    localparam logic [2:0] USE_RS2  = 3'b010;
    localparam logic [2:0] USE_R    = 3'b011;
    localparam logic [2:0] USE_R4   = 3'b111;

    typedef enum logic [2:0] {
        KIND_R4    = 3'd0,
        KIND_R     = 3'd1,
        KIND_LOAD  = 3'd2,
        KIND_STORE = 3'd3,
        KIND_CSR   = 3'd4
    } t_kind;

    typedef struct packed {
        logic [NUM_CYC-1:0][CYC_W-1:0] cycles;
        logic                          zfinx;
    } t_cfg;

    typedef struct packed {
        logic        valid_res;
        t_kind       instr_kind;
        logic [14:0] source_regs;
        logic [2:0]  source_used;
        logic [4:0]  dest_reg;
        logic [31:0] mem_address;
        logic [3:0]  route_flags;
        logic [2:0]  int_operand_use;
        logic [7:0]  exec_cycles;
        logic [2:0]  access_size;
        logic [7:0]  tag_out;
        logic [2:0]  mode_out;
    } t_dec;

endpackage

/* rtl/core/fpid_req_if.sv */
// Input channel of the decoder: instruction, tag, base value and mode.
// Plain valid/ready transfer; no package dependency.
interface fpid_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;
    logic [7:0]  tag_id;
    logic [31:0] base_value;
    logic [2:0]  mode;

    modport source (output valid, output instruction, output tag_id,
                    output base_value, output mode, input ready);
    modport sink   (input valid, input instruction, input tag_id,
                    input base_value, input mode, output ready);
endinterface

/* rtl/core/fpid_rsp_if.sv */
// Output channel of the decoder: one decoded pipeline record per transfer.
// Plain valid/ready transfer; no package dependency.
interface fpid_rsp_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [2:0]  instr_kind;
    logic [14:0] source_regs;
    logic [2:0]  source_used;
    logic [4:0]  dest_reg;
    logic [31:0] mem_address;
    logic [3:0]  route_flags;
    logic [2:0]  int_operand_use;
    logic [7:0]  exec_cycles;
    logic [2:0]  access_size;
    logic [7:0]  tag_out;
    logic [2:0]  mode_out;

    modport source (output valid, output valid_res, output instr_kind,
                    output source_regs, output source_used, output dest_reg,
                    output mem_address, output route_flags, output int_operand_use,
                    output exec_cycles, output access_size, output tag_out,
                    output mode_out, input ready);
    modport sink   (input valid, input valid_res, input instr_kind,
                    input source_regs, input source_used, input dest_reg,
                    input mem_address, input route_flags, input int_operand_use,
                    input exec_cycles, input access_size, input tag_out,
                    input mode_out, output ready);
endinterface

/* rtl/core/fp_instruction_decoder.sv */
// Floating-point instruction decoder top: input stage, decode, result stage.
// Depends on fpid_pkg, fpid_req_if, fpid_rsp_if, fpid_cfg_regs, fpid_decode.
//
//   port      role    transfer rule           content
//   i_req     sink    valid && ready          instruction, tag, base value, mode
//   o_rsp     source  valid && ready          one decoded record per instruction
//   i_cfg_*   write   i_cfg_we high           register index 0..7, 8-bit data
//
// Each instruction passes the input register, then is decoded into the result register.
// One instruction per cycle is taken while o_rsp.ready stays high.
// A stalled result holds in the result register while one more item waits in
// the input register; i_req.ready drops only when both are full and stalled.
// Synchronous active-low reset empties both stages and loads the reset counts.
module fp_instruction_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fpid_req_if.sink                       i_req,
    fpid_rsp_if.source                     o_rsp,
    input  logic                           i_cfg_we,
    input  logic [fpid_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fpid_pkg::CYC_W-1:0]     i_cfg_data
);
    import fpid_pkg::*;

    logic        r_s1_valid;
    logic [31:0] r_s1_instruction;
    logic [7:0]  r_s1_tag_id;
    logic [31:0] r_s1_base_value;
    logic [2:0]  r_s1_mode;
    logic        r_out_valid;
    t_dec        r_out;
    t_dec        n_out;
    t_cfg        cfg;
    logic        load_out;
    logic        load_s1;

    fpid_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    fpid_decode u_dec (
        .i_instruction (r_s1_instruction),
        .i_tag_id      (r_s1_tag_id),
        .i_base_value  (r_s1_base_value),
        .i_mode        (r_s1_mode),
        .i_cfg         (cfg),
        .o_dec         (n_out)
    );

    assign load_out    = !r_out_valid || o_rsp.ready;
    assign load_s1     = !r_s1_valid || load_out;
    assign i_req.ready = load_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_s1) begin
                r_s1_valid <= i_req.valid;
            end
            if (load_out) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_s1 && i_req.valid) begin
            r_s1_instruction <= i_req.instruction;
            r_s1_tag_id      <= i_req.tag_id;
            r_s1_base_value  <= i_req.base_value;
            r_s1_mode        <= i_req.mode;
        end
        if (load_out && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.valid_res       = r_out.valid_res;
    assign o_rsp.instr_kind      = r_out.instr_kind;
    assign o_rsp.source_regs     = r_out.source_regs;
    assign o_rsp.source_used     = r_out.source_used;
    assign o_rsp.dest_reg        = r_out.dest_reg;
    assign o_rsp.mem_address     = r_out.mem_address;
    assign o_rsp.route_flags     = r_out.route_flags;
    assign o_rsp.int_operand_use = r_out.int_operand_use;
    assign o_rsp.exec_cycles     = r_out.exec_cycles;
    assign o_rsp.access_size     = r_out.access_size;
    assign o_rsp.tag_out         = r_out.tag_out;
    assign o_rsp.mode_out        = r_out.mode_out;
endmodule

/* rtl/core/fpid_cfg_regs.sv */
// Configuration registers: cycle counts per operation class and zfinx mode.
// Depends on fpid_pkg.
module fpid_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fpid_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fpid_pkg::CYC_W-1:0]    i_cfg_data,
    output fpid_pkg::t_cfg                o_cfg
);
    import fpid_pkg::*;

    logic [NUM_CYC-1:0][CYC_W-1:0] r_cycles;
    logic                          r_zfinx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycles <= {NUM_CYC{CYC_RESET}};
            r_zfinx  <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ZFINX) begin
                r_zfinx <= i_cfg_data[0];
            end else begin
                r_cycles[i_cfg_idx] <= i_cfg_data;
            end
        end
    end

    assign o_cfg.cycles = r_cycles;
    assign o_cfg.zfinx  = r_zfinx;
endmodule

/* rtl/core/fpid_decode.sv */
// Decode of one registered instruction into a pipeline record.
// Depends on fpid_pkg; fed by the input stage and the configuration registers.
module fpid_decode (
    input  logic [31:0]    i_instruction,
    input  logic [7:0]     i_tag_id,
    input  logic [31:0]    i_base_value,
    input  logic [2:0]     i_mode,
    input  fpid_pkg::t_cfg i_cfg,
    output fpid_pkg::t_dec o_dec
);
    import fpid_pkg::*;

    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [4:0]  f5;
    logic [11:0] csr;
    logic [11:0] imm_ld;
    logic [11:0] imm_st;
    logic [31:0] addr_ld;
    logic [31:0] addr_st;
    logic        valid;
    logic        fp_op;
    t_kind       kind;
    logic [2:0]  used;
    logic [4:0]  dst;
    logic [31:0] addr;
    logic [3:0]  route;
    logic [2:0]  intuse;
    logic [7:0]  cyc;
    logic [2:0]  size;

    assign opc    = i_instruction[6:0];
    assign rd     = i_instruction[11:7];
    assign f3     = i_instruction[14:12];
    assign rs1    = i_instruction[19:15];
    assign rs2    = i_instruction[24:20];
    assign f5     = i_instruction[31:27];
    assign csr    = i_instruction[31:20];
    assign imm_ld = i_instruction[31:20];
    assign imm_st = {i_instruction[31:25], i_instruction[11:7]};
    assign addr_ld = i_base_value + {{20{imm_ld[11]}}, imm_ld};
    assign addr_st = i_base_value + {{20{imm_st[11]}}, imm_st};

    always_comb begin
        valid  = 1'b1;
        fp_op  = 1'b0;
        kind   = KIND_R4;
        used   = USE_NONE;
        dst    = '0;
        addr   = '0;
        route  = '0;
        intuse = USE_NONE;
        cyc    = '0;
        size   = '0;
        unique case (opc)
            OPC_FLW: begin
                kind  = KIND_LOAD;
                dst   = rd;
                addr  = addr_ld;
                route = ROUTE_FROM_MEM;
                size  = f3;
            end
            OPC_FSW: begin
                kind  = KIND_STORE;
                used  = USE_RS2;
                addr  = addr_st;
                route = ROUTE_TO_MEM;
                size  = f3;
            end
            OPC_FMADD, OPC_FMSUB, OPC_FNMSUB, OPC_FNMADD: begin
                kind  = KIND_R4;
                used  = USE_R4;
                dst   = rd;
                fp_op = 1'b1;
            end
            OPC_OPFP: begin
                kind  = KIND_R;
                used  = USE_R;
                dst   = rd;
                fp_op = 1'b1;
                unique case (f5)
                    F5_ADD, F5_SUB: cyc = i_cfg.cycles[CFG_CYC_ADD_SUB];
                    F5_MUL:         cyc = i_cfg.cycles[CFG_CYC_MUL];
                    F5_DIV:         cyc = i_cfg.cycles[CFG_CYC_DIV];
                    F5_SQRT: begin
                        cyc  = i_cfg.cycles[CFG_CYC_SQRT];
                        used = USE_RS1;
                    end
                    F5_SGNJ, F5_MINMAX: cyc = i_cfg.cycles[CFG_CYC_CMP];
                    F5_CMP: begin
                        cyc   = i_cfg.cycles[CFG_CYC_CMP];
                        route = ROUTE_TO_INT;
                    end
                    F5_CVTWS: begin
                        cyc   = i_cfg.cycles[CFG_CYC_CVT];
                        used  = USE_RS1;
                        route = ROUTE_TO_INT;
                    end
                    F5_CVTSW, F5_MVWX: begin
                        cyc    = i_cfg.cycles[CFG_CYC_CVT];
                        used   = USE_RS1;
                        route  = ROUTE_FROM_INT;
                        intuse = USE_RS1;
                    end
                    F5_MVXW: begin
                        cyc   = (f3 <= F3_MV_MAX) ? i_cfg.cycles[CFG_CYC_CVT]
                                                  : i_cfg.cycles[CFG_CYC_DEFAULT];
                        used  = USE_RS1;
                        route = ROUTE_TO_INT;
                    end
                    default: cyc = i_cfg.cycles[CFG_CYC_DEFAULT];
                endcase
            end
            OPC_SYSTEM: begin
                if (csr < CSR_LOW || csr > CSR_HIGH) begin
                    valid = 1'b0;
                end else begin
                    kind  = KIND_CSR;
                    dst   = rd;
                    route = ROUTE_TO_INT;
                    if (f3 == F3_CSRRW) begin
                        used   = USE_RS1;
                        intuse = USE_RS1;
                    end
                end
            end
            default: valid = 1'b0;
        endcase

        if (i_cfg.zfinx) begin
            route = route | ROUTE_TO_INT;
            if (fp_op) begin
                intuse = intuse | used;
            end
        end

        o_dec = '0;
        if (valid) begin
            o_dec.valid_res       = 1'b1;
            o_dec.instr_kind      = kind;
            o_dec.source_regs     = {used[2] ? f5 : 5'd0,
                                     used[1] ? rs2 : 5'd0,
                                     used[0] ? rs1 : 5'd0};
            o_dec.source_used     = used;
            o_dec.dest_reg        = dst;
            o_dec.mem_address     = addr;
            o_dec.route_flags     = route;
            o_dec.int_operand_use = intuse;
            o_dec.exec_cycles     = cyc;
            o_dec.access_size     = size;
        end
        o_dec.tag_out  = i_tag_id;
        o_dec.mode_out = i_mode;
    end
endmodule

/* rtl/core/fpid_checker.sv */
// Port-level checks of the decoder output channel, bound to the top level.
// Depends on fpid_pkg and fp_instruction_decoder_assert.svh.
`include "fp_instruction_decoder_assert.svh"

module fpid_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_valid_res,
    input logic [2:0]  i_instr_kind,
    input logic [2:0]  i_source_used,
    input logic [4:0]  i_dest_reg,
    input logic [31:0] i_mem_address,
    input logic [3:0]  i_route_flags,
    input logic [7:0]  i_exec_cycles,
    input logic [7:0]  i_tag_out
);
    import fpid_pkg::*;

    logic stalled;
    logic invalid_rec;
    logic store_rec;
    logic timed_rec;

    assign stalled     = i_out_valid && !i_out_ready;
    assign invalid_rec = i_out_valid && !i_valid_res;
    assign store_rec   = i_out_valid && i_valid_res && (i_instr_kind == KIND_STORE);
    assign timed_rec   = i_out_valid && (i_exec_cycles != 8'd0);

    `FPID_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, stalled, i_out_valid && $stable(i_dest_reg) && $stable(i_mem_address) && $stable(i_tag_out))
    `FPID_ASSERT_IMPL(a_invalid_zero, i_clk, i_rst_n, invalid_rec, i_instr_kind == 3'd0 && i_mem_address == 32'd0 && i_route_flags == 4'd0 && i_source_used == 3'd0)
    `FPID_ASSERT_IMPL(a_store_shape, i_clk, i_rst_n, store_rec, i_dest_reg == 5'd0 && i_route_flags[1] && i_source_used == USE_RS2 && i_exec_cycles == 8'd0)
    `FPID_ASSERT_IMPL(a_cycles_opfp, i_clk, i_rst_n, timed_rec, i_valid_res && i_instr_kind == KIND_R)
endmodule

bind fp_instruction_decoder fpid_checker u_fpid_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_valid_res   (o_rsp.valid_res),
    .i_instr_kind  (o_rsp.instr_kind),
    .i_source_used (o_rsp.source_used),
    .i_dest_reg    (o_rsp.dest_reg),
    .i_mem_address (o_rsp.mem_address),
    .i_route_flags (o_rsp.route_flags),
    .i_exec_cycles (o_rsp.exec_cycles),
    .i_tag_out     (o_rsp.tag_out)
);

/* verif/fpid_decode_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the floating-point instruction decoder: mirrors the count registers,
// predicts one decoded record per instruction transfer and compares each result transfer.
// Depends on fpid_pkg, fpid_req_if and fpid_rsp_if.
module fpid_decode_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fpid_req_if                            i_req,
    fpid_rsp_if                            i_rsp,
    input  logic                           i_cfg_we,
    input  logic [fpid_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fpid_pkg::CYC_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_result_count,
    output int                             o_pending
);
    import fpid_pkg::*;

    localparam int MAX_REPORTS = 40;

    t_cfg reg_mirror;
    t_dec expected_records[$];
    int   fail_count;
    int   result_count;
    int   pending;

    assign o_fail_count   = fail_count;
    assign o_result_count = result_count;
    assign o_pending      = pending;

    initial begin
        fail_count   = 0;
        result_count = 0;
        pending      = 0;
    end

    function automatic t_dec decode_fp_instr(input logic [31:0] ins, input logic [7:0] tag,
                                             input logic [31:0] base, input logic [2:0] mode);
        t_dec        rec;
        t_kind       kind;
        logic [6:0]  opc;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [4:0]  rs3;
        logic [4:0]  f5;
        logic [2:0]  f3;
        logic [11:0] csr;
        logic [2:0]  used;
        logic [2:0]  intuse;
        logic [3:0]  route;
        logic [7:0]  cyc;
        logic [2:0]  size;
        logic [4:0]  dst;
        logic [31:0] addr;
        logic        ok;
        logic        fp_op;
        opc    = ins[6:0];
        rd     = ins[11:7];
        f3     = ins[14:12];
        rs1    = ins[19:15];
        rs2    = ins[24:20];
        rs3    = ins[31:27];
        f5     = ins[31:27];
        csr    = ins[31:20];
        ok     = 1'b1;
        fp_op  = 1'b0;
        kind   = KIND_R4;
        used   = USE_NONE;
        intuse = USE_NONE;
        route  = '0;
        cyc    = '0;
        size   = '0;
        dst    = '0;
        addr   = '0;
        case (opc)
            OPC_FLW: begin
                kind  = KIND_LOAD;
                dst   = rd;
                addr  = base + {{20{ins[31]}}, ins[31:20]};
                route = ROUTE_FROM_MEM;
                size  = f3;
            end
            OPC_FSW: begin
                kind  = KIND_STORE;
                used  = USE_RS2;
                addr  = base + {{20{ins[31]}}, ins[31:25], ins[11:7]};
                route = ROUTE_TO_MEM;
                size  = f3;
            end
            OPC_FMADD, OPC_FMSUB, OPC_FNMSUB, OPC_FNMADD: begin
                kind  = KIND_R4;
                used  = USE_R4;
                dst   = rd;
                fp_op = 1'b1;
            end
            OPC_OPFP: begin
                kind  = KIND_R;
                used  = USE_R;
                dst   = rd;
                fp_op = 1'b1;
                cyc   = reg_mirror.cycles[CFG_CYC_DEFAULT];
                case (f5)
                    F5_ADD, F5_SUB: cyc = reg_mirror.cycles[CFG_CYC_ADD_SUB];
                    F5_MUL:         cyc = reg_mirror.cycles[CFG_CYC_MUL];
                    F5_DIV:         cyc = reg_mirror.cycles[CFG_CYC_DIV];
                    F5_SQRT: begin
                        cyc  = reg_mirror.cycles[CFG_CYC_SQRT];
                        used = USE_RS1;
                    end
                    F5_SGNJ, F5_MINMAX: cyc = reg_mirror.cycles[CFG_CYC_CMP];
                    F5_CMP: begin
                        cyc   = reg_mirror.cycles[CFG_CYC_CMP];
                        route = ROUTE_TO_INT;
                    end
                    F5_CVTWS: begin
                        cyc   = reg_mirror.cycles[CFG_CYC_CVT];
                        used  = USE_RS1;
                        route = ROUTE_TO_INT;
                    end
                    F5_CVTSW, F5_MVWX: begin
                        cyc    = reg_mirror.cycles[CFG_CYC_CVT];
                        used   = USE_RS1;
                        route  = ROUTE_FROM_INT;
                        intuse = USE_RS1;
                    end
                    F5_MVXW: begin
                        if (f3 <= F3_MV_MAX) begin
                            cyc = reg_mirror.cycles[CFG_CYC_CVT];
                        end
                        used  = USE_RS1;
                        route = ROUTE_TO_INT;
                    end
                    default: begin
                    end
                endcase
            end
            OPC_SYSTEM: begin
                if (csr < CSR_LOW || csr > CSR_HIGH) begin
                    ok = 1'b0;
                end else begin
                    kind  = KIND_CSR;
                    dst   = rd;
                    route = ROUTE_TO_INT;
                    if (f3 == F3_CSRRW) begin
                        used   = USE_RS1;
                        intuse = USE_RS1;
                    end
                end
            end
            default: ok = 1'b0;
        endcase

        if (ok && reg_mirror.zfinx) begin
            route = route | ROUTE_TO_INT;
            if (fp_op) begin
                intuse = intuse | used;
            end
        end

        rec = '0;
        if (ok) begin
            rec.valid_res       = 1'b1;
            rec.instr_kind      = kind;
            rec.source_regs     = {used[2] ? rs3 : 5'd0, used[1] ? rs2 : 5'd0,
                                   used[0] ? rs1 : 5'd0};
            rec.source_used     = used;
            rec.dest_reg        = dst;
            rec.mem_address     = addr;
            rec.route_flags     = route;
            rec.int_operand_use = intuse;
            rec.exec_cycles     = cyc;
            rec.access_size     = size;
        end
        rec.tag_out  = tag;
        rec.mode_out = mode;
        return rec;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_dec want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CYC; i++) begin
                reg_mirror.cycles[i] = CYC_RESET;
            end
            reg_mirror.zfinx = 1'b0;
            expected_records.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ZFINX) begin
                    reg_mirror.zfinx = i_cfg_data[0];
                end else begin
                    reg_mirror.cycles[i_cfg_idx] = i_cfg_data;
                end
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_records.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: result with tag %0h, expected none, actual record %0h",
                                 $time, i_rsp.tag_out, i_rsp.instr_kind);
                    end
                end else begin
                    want = expected_records.pop_front();
                    check_field("valid_res", want.valid_res, i_rsp.valid_res);
                    check_field("instr_kind", want.instr_kind, i_rsp.instr_kind);
                    check_field("source_regs", want.source_regs, i_rsp.source_regs);
                    check_field("source_used", want.source_used, i_rsp.source_used);
                    check_field("dest_reg", want.dest_reg, i_rsp.dest_reg);
                    check_field("mem_address", want.mem_address, i_rsp.mem_address);
                    check_field("route_flags", want.route_flags, i_rsp.route_flags);
                    check_field("int_operand_use", want.int_operand_use,
                                i_rsp.int_operand_use);
                    check_field("exec_cycles", want.exec_cycles, i_rsp.exec_cycles);
                    check_field("access_size", want.access_size, i_rsp.access_size);
                    check_field("tag_out", want.tag_out, i_rsp.tag_out);
                    check_field("mode_out", want.mode_out, i_rsp.mode_out);
                    result_count++;
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_records.push_back(decode_fp_instr(i_req.instruction, i_req.tag_id,
                                                           i_req.base_value, i_req.mode));
            end
        end
        pending = expected_records.size();
    end

endmodule

/* verif/tb_fp_instruction_decoder.sv */
`timescale 1ns / 1ps
// Top of the decoder testbench: clock, reset, instruction stimulus, result stalls and
// register phases. Depends on fpid_pkg, the channel interfaces and fpid_decode_checker.
module tb_fp_instruction_decoder;
    import fpid_pkg::*;

    localparam int         NUM_PHASES = 8;
    localparam int         PHASE_ITEMS = 190;
    localparam logic [4:0] F5_UNUSED = 5'h1F;
    localparam logic [4:0] OPFP_F5 [12] = '{F5_ADD, F5_SUB, F5_MUL, F5_DIV, F5_SGNJ,
                                            F5_MINMAX, F5_SQRT, F5_CMP, F5_CVTWS,
                                            F5_CVTSW, F5_MVXW, F5_MVWX};
    localparam logic [6:0] R4_OPC [4] = '{OPC_FMADD, OPC_FMSUB, OPC_FNMSUB, OPC_FNMADD};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CYC_W-1:0]     cfg_data;
    int                   fail_count;
    int                   result_count;
    int                   pending_count;
    int                   sent_count;
    int                   rsp_hold_cycles;

    fpid_req_if req_if ();
    fpid_rsp_if rsp_if ();

    fp_instruction_decoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    fpid_decode_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req_if),
        .i_rsp          (rsp_if),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_result_count (result_count),
        .o_pending      (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d of %0d results checked", result_count, sent_count);
        $display("TB_ERROR");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_instr();
        logic [31:0] w;
        int          sel;
        int          csr_sel;
        w   = $urandom();
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            w[6:0] = OPC_FLW;
        end else if (sel < 30) begin
            w[6:0] = OPC_FSW;
        end else if (sel < 45) begin
            w[6:0] = R4_OPC[$urandom_range(0, 3)];
        end else if (sel < 75) begin
            w[6:0] = OPC_OPFP;
            if ($urandom_range(0, 9) != 0) begin
                w[31:27] = OPFP_F5[$urandom_range(0, 11)];
            end
        end else if (sel < 90) begin
            w[6:0]  = OPC_SYSTEM;
            csr_sel = $urandom_range(0, 9);
            if (csr_sel < 7) begin
                w[31:20] = 12'($urandom_range(CSR_LOW, CSR_HIGH));
            end else if (csr_sel == 7) begin
                w[31:20] = CSR_LOW - 12'd1;
            end else if (csr_sel == 8) begin
                w[31:20] = CSR_HIGH + 12'd1;
            end
            if ($urandom_range(0, 1) == 1) begin
                w[14:12] = F3_CSRRW;
            end
        end
        return w;
    endfunction

    // hold valid across back-to-back transfers, drop it only for a gap
    task automatic send_instr(input logic [31:0] ins, input logic [7:0] tag,
                              input logic [31:0] base, input logic [2:0] mode,
                              input bit gapless);
        int gap;
        gap = gapless ? 0 : idle_len();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.instruction <= ins;
        req_if.tag_id      <= tag;
        req_if.base_value  <= base;
        req_if.mode        <= mode;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic program_regs(input logic [NUM_CYC-1:0][CYC_W-1:0] counts, input logic zf);
        cfg_we <= 1'b1;
        for (int i = 0; i < NUM_CYC; i++) begin
            cfg_idx  <= CFG_IDX_W'(i);
            cfg_data <= counts[i];
            @(posedge i_clk);
        end
        cfg_idx  <= CFG_ZFINX;
        cfg_data <= {7'($urandom()), zf};
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin : rsp_ready_gen
        int left;
        bit level;
        left  = 0;
        level = 1'b1;
        forever begin
            if (rsp_hold_cycles > 0) begin
                level           = 1'b0;
                left            = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end else if (left == 0) begin
                if (level) begin
                    left  = idle_len();
                    level = (left == 0);
                end else begin
                    level = 1'b1;
                end
                if (level) begin
                    left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 12);
                end
            end
            rsp_if.ready <= level;
            left--;
            @(posedge i_clk);
        end
    end

    initial begin
        logic [31:0]                   w;
        logic [NUM_CYC-1:0][CYC_W-1:0] counts;
        logic                          zf;
        bit                            gapless;
        sent_count      = 0;
        rsp_hold_cycles = 0;
        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= '0;
        cfg_data           <= '0;
        req_if.valid       <= 1'b0;
        req_if.instruction <= '0;
        req_if.tag_id      <= '0;
        req_if.base_value  <= '0;
        req_if.mode        <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: address wrap and sign, every format and OP-FP operation, csr bounds
        send_instr({12'h7FF, 5'd1, 3'b010, 5'd31, OPC_FLW}, 8'h00, 32'hFFFF_FFFF, 3'd0, 1'b0);
        send_instr({12'h800, 5'd31, 3'b111, 5'd0, OPC_FLW}, 8'hFF, 32'h0000_0000, 3'd7, 1'b0);
        send_instr({7'h40, 5'd31, 5'd7, 3'b010, 5'h00, OPC_FSW}, 8'h5A, 32'h8000_0000, 3'd3,
                   1'b0);
        send_instr({7'h3F, 5'd5, 5'd6, 3'b000, 5'h1F, OPC_FSW}, 8'hA5, 32'hFFFF_F000, 3'd4,
                   1'b0);
        for (int i = 0; i < 4; i++) begin
            send_instr({5'd31, 2'b00, 5'd30, 5'd29, 3'b111, 5'd28, R4_OPC[i]}, 8'(i),
                       $urandom(), 3'(i), 1'b0);
        end
        for (int i = 0; i < 12; i++) begin
            w        = $urandom();
            w[31:27] = OPFP_F5[i];
            w[6:0]   = OPC_OPFP;
            if (OPFP_F5[i] == F5_MVXW) begin
                w[14:12] = F3_MV_MAX;
            end
            send_instr(w, 8'(i + 16), $urandom(), 3'($urandom()), 1'b0);
        end
        w        = $urandom();
        w[31:27] = F5_MVXW;
        w[14:12] = F3_MV_MAX + 3'd1;
        w[6:0]   = OPC_OPFP;
        send_instr(w, 8'h40, $urandom(), 3'd1, 1'b0);
        w        = $urandom();
        w[31:27] = F5_UNUSED;
        w[6:0]   = OPC_OPFP;
        send_instr(w, 8'h41, $urandom(), 3'd2, 1'b0);
        send_instr({CSR_LOW - 12'd1, 5'd9, F3_CSRRW, 5'd10, OPC_SYSTEM}, 8'h50, $urandom(),
                   3'd5, 1'b0);
        send_instr({CSR_LOW, 5'd31, F3_CSRRW, 5'd1, OPC_SYSTEM}, 8'h51, $urandom(), 3'd6,
                   1'b0);
        send_instr({CSR_HIGH, 5'd17, 3'b010, 5'd31, OPC_SYSTEM}, 8'h52, $urandom(), 3'd0,
                   1'b0);
        send_instr({CSR_HIGH + 12'd1, 5'd3, F3_CSRRW, 5'd4, OPC_SYSTEM}, 8'h53, $urandom(),
                   3'd7, 1'b0);
        send_instr(32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 3'd7, 1'b0);
        req_if.valid <= 1'b0;
        wait (result_count == sent_count);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            for (int k = 0; k < NUM_CYC; k++) begin
                case (ph)
                    0: counts[k] = 8'h00;
                    1: counts[k] = 8'hFF;
                    2: counts[k] = 8'(k * 16 + 3);
                    default: counts[k] = 8'($urandom());
                endcase
            end
            case (ph)
                0: zf = 1'b1;
                1: zf = 1'b0;
                2: zf = 1'b1;
                default: zf = 1'($urandom());
            endcase
            program_regs(counts, zf);
            if (ph == 2) begin
                rsp_hold_cycles = 80;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                gapless = (ph == 2 && n < 40) || (n >= 100 && n < 130);
                send_instr(rand_instr(), 8'($urandom()), $urandom(), 3'($urandom()), gapless);
            end
            // drop valid and let every result drain before the next register setting
            req_if.valid <= 1'b0;
            wait (result_count == sent_count);
        end

        repeat (10) @(posedge i_clk);
        $display("Checked %0d decoded records over %0d register settings,", result_count,
                 NUM_PHASES + 1);
        $display("zfinx on and off, cycle counts 0 to 255, random stalls and a full hold-off.");
        if (fail_count == 0 && pending_count == 0 && result_count == sent_count) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/fpid_pkg.sv
rtl/core/fpid_req_if.sv
rtl/core/fpid_rsp_if.sv
rtl/core/fpid_cfg_regs.sv
rtl/core/fpid_decode.sv
rtl/core/fp_instruction_decoder.sv
rtl/core/fpid_checker.sv
verif/fpid_decode_checker.sv
verif/tb_fp_instruction_decoder.sv
